### src/pcd_pkg.sv
// Shared types and constants for the pulse-count dimming driver.
`timescale 1ns / 1ps

package pcd_pkg;

   // Request and response payloads
   typedef struct packed {
      logic              func;
      logic signed [7:0] percent;
   } pcd_req_type;

   typedef struct packed {
      logic       enable_level;
      logic       busy_res;
      logic [4:0] target_level;
   } pcd_rsp_type;

   // Request function codes
   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_SET  = 1'b1;

   // Register map
   localparam int             CSR_IDX_W      = 1;
   localparam int             CSR_DATA_W     = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_RESET_LOW  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_HALF = 1'd1;

   // Register reset values
   localparam logic [15:0] RESET_LOW_DEFAULT  = 16'd5000;
   localparam logic [9:0]  PULSE_HALF_DEFAULT = 10'd200;

   // Level mapping: 1 + (p-1)*15/99, with *15/99 as a multiply by 15*2^16/99 (rounded up)
   localparam logic [6:0]  PERCENT_MAX   = 7'd100;
   localparam logic [13:0] LEVEL_RECIP   = 14'd9930;
   localparam int          LEVEL_SHIFT   = 16;
   localparam logic [4:0]  LEVEL_FULL    = 5'd16;

endpackage

### src/pulse_count_dimming_driver.sv
// Top level: request and response registers, control registers, sequencer.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------
//  req     | in        | req_valid/req_stall | req_data  (func, percent)
//  rsp     | out       | rsp_valid/rsp_stall | rsp_data  (enable_level, busy_res,
//          |           |                     |            target_level)
//  csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
//  One request per clock sustained while rsp_stall is low; a response passes
//  through the input register, then the result register, after the request
//  is taken.
//  The single-pass sequencer update between the two registers sets that rate.
//  Reset is synchronous; it clears the sequencer and valid flags and loads the control register defaults.
//  A stalled response holds the result register; the input register still
//  drains into it once it frees, and req_stall rises only when both are full.
`timescale 1ns / 1ps

module pulse_count_dimming_driver
   import pcd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pcd_req_type           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output pcd_rsp_type           rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic        in_vld_ff,  in_vld_in;
   pcd_req_type in_data_ff;
   logic        out_vld_ff, out_vld_in;
   pcd_rsp_type out_data_ff;
   pcd_rsp_type rsp_next;
   logic [15:0] reset_low_ff;
   logic [9:0]  pulse_half_ff;
   logic        advance;
   logic        req_take;

   // Move the held request on when the result register is free or draining
   always_comb begin
      advance    = in_vld_ff && (!out_vld_ff || !rsp_stall);
      req_stall  = in_vld_ff && !advance;
      req_take   = req_valid && !req_stall;
      in_vld_in  = req_take || (in_vld_ff && !advance);
      out_vld_in = advance || (out_vld_ff && rsp_stall);
   end

   pcd_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .req              (in_data_ff),
      .reset_low_ticks  (reset_low_ff),
      .pulse_half_ticks (pulse_half_ff),
      .rsp_next         (rsp_next)
   );

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= rsp_next;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         reset_low_ff  <= RESET_LOW_DEFAULT;
         pulse_half_ff <= PULSE_HALF_DEFAULT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RESET_LOW:  reset_low_ff  <= csr_wdata[15:0];
            CSR_PULSE_HALF: pulse_half_ff <= csr_wdata[9:0];
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_vld_ff && out_vld_ff && rsp_stall))
      else $error("request stalled with room in the pipeline");

   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_vld_ff)
      else $error("processed request produced no response");

   a_take_fills_input: assert property (@(posedge clock) disable iff (reset)
      req_take |=> in_vld_ff)
      else $error("accepted request lost from the input register");

endmodule

### src/pcd_level.sv
// Maps a positive brightness percent to a dimmer level of 1 to 16.
`timescale 1ns / 1ps

module pcd_level
   import pcd_pkg::*;
(
   input  logic signed [7:0] percent,
   output logic [4:0]        level
);

   logic [6:0]  pct_clamp;
   logic [6:0]  pct_m1;
   logic [19:0] prod;

   // Clamp to 100, then scale (p-1)*15/99 by a reciprocal multiply
   always_comb begin
      pct_clamp = (percent > $signed({1'b0, PERCENT_MAX})) ? PERCENT_MAX : percent[6:0];
      pct_m1    = pct_clamp - 7'd1;
      prod      = 20'(pct_m1) * 20'(LEVEL_RECIP);
      level     = {1'b0, prod[LEVEL_SHIFT+3:LEVEL_SHIFT]} + 5'd1;
   end

endmodule

### src/pcd_seq.sv
// Reset and pulse sequencer: phase, tick counter, pulse count and pin state.
`timescale 1ns / 1ps

module pcd_seq
   import pcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  pcd_req_type req,
   input  logic [15:0] reset_low_ticks,
   input  logic [9:0]  pulse_half_ticks,
   output pcd_rsp_type rsp_next
);

   localparam logic [2:0] PH_OFF   = 3'd0;
   localparam logic [2:0] PH_RESET = 3'd1;
   localparam logic [2:0] PH_HIGH  = 3'd2;
   localparam logic [2:0] PH_LOW   = 3'd3;
   localparam logic [2:0] PH_ON    = 3'd4;

   logic [2:0]  phase_ff,   phase_in;
   logic [15:0] tick_ff,    tick_in;
   logic [3:0]  pulses_ff,  pulses_in;
   logic [4:0]  level_ff,   level_in;
   logic        pin_ff,     pin_in;

   logic [4:0]  set_level;
   logic [16:0] tick_inc;
   logic        reset_done;
   logic        half_done;
   logic [3:0]  pulses_dec;
   logic        pct_off;

   pcd_level u_level (
      .percent (req.percent),
      .level   (set_level)
   );

   // Phase end checks; a zero limit ends the phase after one tick
   always_comb begin
      tick_inc   = {1'b0, tick_ff} + 17'd1;
      reset_done = tick_inc >= {1'b0, reset_low_ticks};
      half_done  = tick_inc >= {7'b0, pulse_half_ticks};
      pulses_dec = pulses_ff - 4'd1;
      pct_off    = req.percent[7] || (req.percent == 8'sd0);
   end

   // Next state for the request in the input register
   always_comb begin
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      pulses_in = pulses_ff;
      level_in  = level_ff;
      pin_in    = pin_ff;
      if (req.func == FUNC_SET) begin
         tick_in = 16'd0;
         pin_in  = 1'b0;
         if (pct_off) begin
            phase_in  = PH_OFF;
            pulses_in = 4'd0;
            level_in  = 5'd0;
         end else begin
            phase_in  = PH_RESET;
            level_in  = set_level;
            pulses_in = 4'(LEVEL_FULL - set_level);
         end
      end else begin
         unique case (phase_ff)
            PH_RESET: begin
               if (reset_done) begin
                  tick_in  = 16'd0;
                  pin_in   = 1'b1;
                  phase_in = (pulses_ff != 4'd0) ? PH_HIGH : PH_ON;
               end else begin
                  tick_in = tick_inc[15:0];
               end
            end
            PH_HIGH: begin
               if (half_done) begin
                  tick_in  = 16'd0;
                  pin_in   = 1'b0;
                  phase_in = PH_LOW;
               end else begin
                  tick_in = tick_inc[15:0];
               end
            end
            PH_LOW: begin
               if (half_done) begin
                  tick_in   = 16'd0;
                  pulses_in = pulses_dec;
                  pin_in    = 1'b1;
                  phase_in  = (pulses_dec != 4'd0) ? PH_HIGH : PH_ON;
               end else begin
                  tick_in = tick_inc[15:0];
               end
            end
            default: begin
               // hold while off or steady on
            end
         endcase
      end
   end

   // Response fields follow the state after this request
   always_comb begin
      rsp_next.enable_level = pin_in;
      rsp_next.busy_res     = (phase_in == PH_RESET) || (phase_in == PH_HIGH) ||
                              (phase_in == PH_LOW);
      rsp_next.target_level = level_in;
   end

   // Advance state once per processed request
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_OFF;
         tick_ff   <= 16'd0;
         pulses_ff <= 4'd0;
         level_ff  <= 5'd0;
         pin_ff    <= 1'b0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         tick_ff   <= tick_in;
         pulses_ff <= pulses_in;
         level_ff  <= level_in;
         pin_ff    <= pin_in;
      end
   end

   a_off_no_pulses: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_OFF) |-> (pulses_ff == 4'd0 && level_ff == 5'd0 && !pin_ff))
      else $error("off phase with pending pulses, level or high pin");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LEVEL_FULL)
      else $error("held level above full scale");

   a_pin_high_phases: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ON || phase_ff == PH_HIGH) |-> pin_ff)
      else $error("pin low in a high phase");

   a_pin_low_phases: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_RESET || phase_ff == PH_LOW) |-> !pin_ff)
      else $error("pin high in a low phase");

   a_pulses_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_OFF) |-> ({1'b0, pulses_ff} + level_ff <= LEVEL_FULL))
      else $error("pulse count exceeds what the level allows");

endmodule

### tb/dimming_scoreboard.sv
// Scoreboard class: dimming sequencer prediction and response checking.
`timescale 1ns / 1ps

package dimming_tb_pkg;
   import pcd_pkg::*;

   typedef enum logic [2:0] {
      SEQ_OFF,
      SEQ_RESET,
      SEQ_HIGH,
      SEQ_LOW,
      SEQ_ON
   } seq_phase_type;

   class dimming_scoreboard;
      // Register copies
      logic [15:0]   reset_low;
      logic [9:0]    pulse_half;
      // Sequencer copy
      seq_phase_type phase;
      logic [15:0]   tick_count;
      logic [3:0]    pulses_left;
      logic [4:0]    level_held;
      logic          pin_level;
      // Responses still owed by the block, oldest first
      pcd_rsp_type   expected_rsp[$];
      int            errors;

      function new();
         reset_low   = RESET_LOW_DEFAULT;
         pulse_half  = PULSE_HALF_DEFAULT;
         phase       = SEQ_OFF;
         tick_count  = '0;
         pulses_left = '0;
         level_held  = '0;
         pin_level   = 1'b0;
         errors      = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] wdata);
         if (index == CSR_RESET_LOW) begin
            reset_low = wdata;
         end else if (index == CSR_PULSE_HALF) begin
            pulse_half = wdata[9:0];
         end
      endfunction

      // Count one tick and report whether a phase of this span is over.
      // A span of zero or one ends the phase on the first tick; a count that
      // already passed a newly written span ends it on the next tick.
      function bit tick_ends_phase(logic [15:0] span);
         logic [16:0] next_count;
         next_count = {1'b0, tick_count} + 17'd1;
         if (next_count >= {1'b0, span}) begin
            tick_count = '0;
            return 1'b1;
         end
         tick_count = next_count[15:0];
         return 1'b0;
      endfunction

      // Raise the pin; start the next step pulse or settle at steady on
      function void raise_pin();
         pin_level = 1'b1;
         phase     = (pulses_left != 0) ? SEQ_HIGH : SEQ_ON;
      endfunction

      // Advance the sequencer by one accepted request and queue its response
      function void note_request(pcd_req_type req);
         int          pct;
         pcd_rsp_type rsp;
         pct = $signed(req.percent);
         if (req.func == FUNC_SET) begin
            tick_count = '0;
            pin_level  = 1'b0;
            if (pct <= 0) begin
               phase       = SEQ_OFF;
               pulses_left = '0;
               level_held  = '0;
            end else begin
               if (pct > 100) pct = 100;
               level_held  = 5'(1 + (pct - 1) * 15 / 99);
               pulses_left = 4'(16 - level_held);
               phase       = SEQ_RESET;
            end
         end else begin
            case (phase)
               SEQ_RESET: begin
                  if (tick_ends_phase(reset_low)) raise_pin();
               end
               SEQ_HIGH: begin
                  if (tick_ends_phase({6'd0, pulse_half})) begin
                     pin_level = 1'b0;
                     phase     = SEQ_LOW;
                  end
               end
               SEQ_LOW: begin
                  if (tick_ends_phase({6'd0, pulse_half})) begin
                     pulses_left = pulses_left - 4'd1;
                     raise_pin();
                  end
               end
               default: ;
            endcase
         end
         rsp.enable_level = pin_level;
         rsp.busy_res     = (phase == SEQ_RESET || phase == SEQ_HIGH || phase == SEQ_LOW);
         rsp.target_level = level_held;
         expected_rsp.push_back(rsp);
      endfunction

      // Compare one response with the oldest expectation
      function void check_response(pcd_rsp_type got);
         pcd_rsp_type want;
         if (expected_rsp.size() == 0) begin
            $error("response %h arrived with no request pending", got);
            errors++;
            return;
         end
         want = expected_rsp.pop_front();
         if (got.enable_level !== want.enable_level) begin
            $error("enable_level: expected %0d, got %0d", want.enable_level, got.enable_level);
            errors++;
         end
         if (got.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
            errors++;
         end
         if (got.target_level !== want.target_level) begin
            $error("target_level: expected %0d, got %0d", want.target_level, got.target_level);
            errors++;
         end
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction
   endclass

endpackage

### tb/tb_top.sv
// Testbench top: drives requests and register writes, checks every response.
`timescale 1ns / 1ps

module tb_top;
   import pcd_pkg::*;
   import dimming_tb_pkg::*;

   localparam int IDLE_LIMIT   = 1000;
   localparam int RANDOM_ITEMS = 1450;
   localparam int ROUND_ITEMS  = 120;
   localparam int MAX_TICK_RUN = 300;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   pcd_req_type           req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   pcd_rsp_type           rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dimming_scoreboard sb = new();
   bit                no_idling = 1'b0;
   int                random_sent = 0;
   int                stall_left = 0;

   pulse_count_dimming_driver u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Take responses, then hold off for a random number of cycles
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_response(rsp_data);
         stall_left = no_idling ? 0 : $urandom_range(0, 10);
      end else if (stall_left > 0) begin
         stall_left--;
      end
      rsp_stall <= (stall_left != 0);
   end

   // Drop the run if no channel moves for too long
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("tb_top: errors");
      $finish;
   end

   // Send one request after a random gap; hold it until taken
   task automatic send_request(logic func, logic [7:0] percent);
      pcd_req_type item;
      int          gap;
      item.func    = func;
      item.percent = percent;
      gap = no_idling ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      sb.note_request(item);
   endtask

   // Write both registers back to back; valid stays high between them
   task automatic set_registers(logic [15:0] low_ticks, logic [15:0] half_ticks);
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] value;
      for (int i = 0; i < 2; i++) begin
         index = (i == 0) ? CSR_RESET_LOW : CSR_PULSE_HALF;
         value = (i == 0) ? low_ticks : half_ticks;
         csr_valid <= 1'b1;
         csr_index <= index;
         csr_wdata <= value;
         do @(posedge clock); while (!csr_ready);
         sb.write_register(index, value);
      end
      csr_valid <= 1'b0;
   endtask

   // Stop sending and wait until every response is in
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [7:0] draw_set_percent();
      case ($urandom_range(0, 9))
         0:       return 8'($urandom);
         1:       return 8'(-int'($urandom_range(0, 128)));
         2:       return 8'($urandom_range(101, 127));
         default: return 8'($urandom_range(1, 100));
      endcase
   endfunction

   // Send a set request, then ticks that finish the sequence or cut it short
   task automatic run_sequence();
      int low_span;
      int half_span;
      int span;
      int ticks;
      send_request(FUNC_SET, draw_set_percent());
      low_span  = (sb.reset_low == 0) ? 1 : int'(sb.reset_low);
      half_span = (sb.pulse_half == 0) ? 1 : int'(sb.pulse_half);
      span = (sb.level_held == 0) ? 3 : low_span + 2 * (16 - int'(sb.level_held)) * half_span;
      if ($urandom_range(0, 3) == 0) begin
         ticks = $urandom_range(0, span);
      end else begin
         ticks = span + $urandom_range(0, 4);
      end
      if (ticks > MAX_TICK_RUN) ticks = $urandom_range(20, MAX_TICK_RUN);
      repeat (ticks) send_request(FUNC_TICK, 8'($urandom));
      random_sent += ticks + 1;
   endtask

   initial begin
      int round_end;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      rsp_stall <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: default register values
      send_request(FUNC_TICK, 8'h00);   // tick while off
      send_request(FUNC_SET, 8'h00);    // zero percent stays off
      send_request(FUNC_SET, 8'h80);    // most negative percent
      send_request(FUNC_SET, 8'h7F);    // clamps to 100
      send_request(FUNC_TICK, 8'hFF);   // percent ignored on a tick
      send_request(FUNC_TICK, 8'h55);
      send_request(FUNC_SET, 8'd50);    // restart mid-sequence
      send_request(FUNC_TICK, 8'hAA);
      send_request(FUNC_SET, 8'hFF);    // negative percent ends the sequence
      drain();

      // Directed: zero registers behave as one tick per phase
      set_registers(16'd0, 16'd0);
      send_request(FUNC_SET, 8'd100);   // full level, no pulses
      send_request(FUNC_TICK, 8'h00);   // pin goes high right after reset phase
      send_request(FUNC_TICK, 8'h00);   // steady on
      send_request(FUNC_SET, 8'd1);     // lowest level
      repeat (4) send_request(FUNC_TICK, 8'h01);
      send_request(FUNC_SET, 8'd101);
      send_request(FUNC_SET, 8'd2);
      repeat (3) send_request(FUNC_TICK, 8'hFE);
      drain();

      // Random rounds, each with its own register setting and idling mode
      for (int round = 0; random_sent < RANDOM_ITEMS; round++) begin
         no_idling = ($urandom_range(0, 3) == 0);
         case (round % 6)
            0: set_registers(16'($urandom_range(1, 6)), 16'($urandom_range(1, 4)));
            1: set_registers(16'd1, 16'd1);
            2: set_registers(16'd0, 16'd0);
            3: set_registers(16'($urandom), 16'($urandom));
            4: set_registers(16'hFFFF, 16'hFFFF);
            default: set_registers(16'($urandom_range(2, 12)), 16'($urandom_range(1, 6)));
         endcase
         round_end = random_sent + ROUND_ITEMS;
         while (random_sent < round_end) begin
            if ($urandom_range(0, 9) == 0) begin
               send_request(1'($urandom), 8'($urandom));
               random_sent++;
            end else begin
               run_sequence();
            end
         end
         drain();
      end

      if (sb.errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

### pulse_count_dimming_driver.f
src/pcd_pkg.sv
src/pcd_level.sv
src/pcd_seq.sv
src/pulse_count_dimming_driver.sv
tb/dimming_scoreboard.sv
tb/tb_top.sv
